// File: src/lzfd_pkg.sv
// Package for the LZF stream decompressor: widths, token phases, halt codes.
// No dependencies.
`default_nettype none
package lzfd_pkg;
	localparam int WINDOW_BYTES = 8192;
	localparam int OUT_LANES    = 8;
	localparam int COUNT_BITS   = 24;
	localparam int WIN_BITS     = $clog2(WINDOW_BYTES);
	localparam int LANE_BITS    = $clog2(OUT_LANES + 1);

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_LIT  = 2'd1,
		PH_EXT  = 2'd2,
		PH_DIST = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_DONE = 2'd1,
		ST_CAP  = 2'd2,
		ST_DIST = 2'd3
	} status_t;

	// Top-level sequencer states
	typedef enum logic [1:0] {
		FS_IDLE = 2'd0,
		FS_COPY = 2'd1,
		FS_OUT  = 2'd2
	} fsm_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_LANES-1:0][7:0] bytes;
		logic [LANE_BITS-1:0]      byte_count;
		logic                      run_last;
		status_t                   end_status;
		logic [COUNT_BITS-1:0]     total_out;
	} out_beat_t;
endpackage
`default_nettype wire

// File: src/lzfd_stream_if.sv
// Valid/ready channel carrying one beat of a generic payload type.
// No dependencies; the payload type is a parameter.
`default_nettype none
interface lzfd_stream_if #(parameter type payload_t = logic) (input wire logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/lzf_stream_decompressor.sv
// LZF stream decompressor top level: token decoder, history memory, match copy.
// Depends on lzfd_pkg and lzfd_stream_if.
//
// Usage: compressed bytes enter on channel "in" one beat at a time (in_byte,
// last_in). Results leave on channel "out" as words of up to 8 bytes with
// byte_count, run_last, end_status and total_out. Every input beat yields at
// least one output word; the last word for a beat has run_last set.
// Control and extension bytes, literals and a distance byte that halts each
// give one word. A match of L bytes reads each byte from the single-port
// 8192-byte history and writes it back before the next read; the next beat
// is taken only after the final word of the match is issued. Full words
// leave while the copy runs.
// A new beat is accepted only when the output register is empty or drains in
// that cycle, so a receiver stall holds off input and pauses the copy at each
// full word.
// Reset clears all stream state and sets out_capacity to 0; the history contents
// stay undefined, and a match never reaches unwritten entries. The user must
// write out_capacity through cfg_we/cfg_data only while idle; it is unchecked.
`default_nettype none
module lzf_stream_decompressor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_data,
	lzfd_stream_if.sink      in_ch,
	lzfd_stream_if.source    out_ch
);
	import lzfd_pkg::*;

	logic [7:0] hist_mem [WINDOW_BYTES];
	logic [COUNT_BITS-1:0] cap_q, produced_q;
	logic [WIN_BITS-1:0]   widx_q, src_q;
	phase_t                phase_q;
	logic [5:0]            lit_left_q;
	logic [8:0]            mlen_q;
	logic [4:0]            dhi_q;
	status_t               halt_q;
	fsm_t                  state_q, state_d;
	logic [8:0]            copy_left_q;
	logic                  rd_pend_q;
	logic                  last_q;
	logic [7:0]            rd_data_s1;

	// Output register and word assembly
	logic                          ovalid_q;
	out_beat_t                     obeat_q;
	logic [OUT_LANES-1:0][7:0]     wbytes_q;
	logic [LANE_BITS-1:0]          wcnt_q;

	in_beat_t ib;
	assign ib = in_ch.data;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = obeat_q;

	logic oslot_free;
	assign oslot_free = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == FS_IDLE) && oslot_free;

	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	// Match checks at the distance byte
	logic [COUNT_BITS:0] need_len;
	logic [13:0]         back;
	logic                cap_bad, dist_bad;
	always_comb begin
		need_len = {1'b0, produced_q} + {{(COUNT_BITS-8){1'b0}}, mlen_q}
			+ (COUNT_BITS+1)'(2);
		back     = {1'b0, dhi_q, ib.in_byte} + 14'd1;
		cap_bad  = need_len > {1'b0, cap_q};
		dist_bad = {{(COUNT_BITS-14){1'b0}}, back} > produced_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: if (acc && halt_q == ST_RUN && phase_q == PH_DIST && !cap_bad && !dist_bad)
				state_d = FS_COPY;
			FS_COPY: if (copy_left_q == '0 && !rd_pend_q) state_d = FS_OUT;
			FS_OUT:  if (oslot_free) state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	// History read (registered)
	logic do_rd;
	logic wfull;
	assign wfull = wcnt_q == LANE_BITS'(OUT_LANES);
	assign do_rd = state_q == FS_COPY && copy_left_q != '0 && !rd_pend_q &&
		(!wfull || oslot_free);
	always_ff @(posedge clk) begin
		if (do_rd) rd_data_s1 <= hist_mem[src_q];
	end

	// History write on each produced byte
	logic       wr_en;
	logic [7:0] wr_byte;
	always_comb begin
		wr_en   = 1'b0;
		wr_byte = ib.in_byte;
		if (acc && halt_q == ST_RUN && phase_q == PH_LIT) wr_en = 1'b1;
		if (rd_pend_q) begin
			wr_en   = 1'b1;
			wr_byte = rd_data_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en) hist_mem[widx_q] <= wr_byte;
	end

	// Stream state and output sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			cap_q       <= '0;
			produced_q  <= '0;
			widx_q      <= '0;
			src_q       <= '0;
			phase_q     <= PH_CTRL;
			lit_left_q  <= '0;
			mlen_q      <= '0;
			dhi_q       <= '0;
			halt_q      <= ST_RUN;
			copy_left_q <= '0;
			rd_pend_q   <= 1'b0;
			last_q      <= 1'b0;
			ovalid_q    <= 1'b0;
			wcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_data;
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			rd_pend_q <= do_rd;
			if (wr_en) begin
				widx_q     <= widx_q + 1'b1;
				produced_q <= produced_q + 1'b1;
			end
			if (acc) begin
				status_t st;
				logic [7:0] b;
				b  = ib.in_byte;
				st = halt_q;
				ovalid_q                <= 1'b1;
				obeat_q.bytes           <= '0;
				obeat_q.byte_count      <= '0;
				obeat_q.run_last        <= 1'b1;
				obeat_q.total_out       <= produced_q;
				last_q                  <= ib.last_in;
				if (halt_q == ST_RUN) begin
					unique case (phase_q)
						PH_CTRL: begin
							if (produced_q >= cap_q) st = ST_CAP;
							else if (b < 8'h20) begin
								if ({1'b0, produced_q} + {{(COUNT_BITS-7){1'b0}}, b}
									+ (COUNT_BITS+1)'(1) > {1'b0, cap_q}) st = ST_CAP;
								else begin
									lit_left_q <= 6'(b) + 6'd1;
									phase_q    <= PH_LIT;
								end
							end else begin
								dhi_q   <= b[4:0];
								mlen_q  <= 9'(b[7:5]);
								phase_q <= (b[7:5] == 3'd7) ? PH_EXT : PH_DIST;
							end
						end
						PH_LIT: begin
							obeat_q.bytes[0]   <= b;
							obeat_q.byte_count <= LANE_BITS'(1);
							obeat_q.total_out  <= produced_q + 1'b1;
							lit_left_q         <= lit_left_q - 6'd1;
							if (lit_left_q == 6'd1) phase_q <= PH_CTRL;
						end
						PH_EXT: begin
							mlen_q  <= 9'd7 + 9'(b);
							phase_q <= PH_DIST;
						end
						PH_DIST: begin
							phase_q <= PH_CTRL;
							if (cap_bad) st = ST_CAP;
							else if (dist_bad) st = ST_DIST;
							else begin
								ovalid_q    <= 1'b0;
								copy_left_q <= mlen_q + 9'd2;
								src_q       <= widx_q - WIN_BITS'(back);
								wcnt_q      <= '0;
								wbytes_q    <= '0;
							end
						end
						default: ;
					endcase
				end
				halt_q <= st;
				obeat_q.end_status <= (st != ST_RUN) ? st :
					(ib.last_in ? ST_DONE : ST_RUN);
				if (ib.last_in && !(halt_q == ST_RUN && phase_q == PH_DIST && !cap_bad
					&& !dist_bad)) begin
					phase_q    <= PH_CTRL;
					lit_left_q <= '0;
					mlen_q     <= '0;
					dhi_q      <= '0;
					halt_q     <= ST_RUN;
				end
			end
			// Match copy: issue reads, pack returned bytes into words
			if (do_rd) begin
				src_q       <= src_q + 1'b1;
				copy_left_q <= copy_left_q - 9'd1;
				if (wfull) begin
					ovalid_q           <= 1'b1;
					obeat_q.bytes      <= wbytes_q;
					obeat_q.byte_count <= wcnt_q;
					obeat_q.run_last   <= 1'b0;
					obeat_q.end_status <= ST_RUN;
					obeat_q.total_out  <= produced_q;
					wcnt_q             <= '0;
					wbytes_q           <= '0;
				end
			end
			if (rd_pend_q) begin
				wbytes_q[wcnt_q[LANE_BITS-2:0]] <= rd_data_s1;
				wcnt_q <= wcnt_q + 1'b1;
			end
			// Final word of a match
			if (state_q == FS_OUT && oslot_free) begin
				ovalid_q           <= 1'b1;
				obeat_q.bytes      <= wbytes_q;
				obeat_q.byte_count <= wcnt_q;
				obeat_q.run_last   <= 1'b1;
				obeat_q.end_status <= last_q ? ST_DONE : ST_RUN;
				obeat_q.total_out  <= produced_q;
				if (last_q) begin
					produced_q <= '0;
					widx_q     <= '0;
					mlen_q     <= '0;
					dhi_q      <= '0;
				end
			end
			if (acc && ib.last_in && !(halt_q == ST_RUN && phase_q == PH_DIST && !cap_bad
				&& !dist_bad)) begin
				produced_q <= '0;
				widx_q     <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// File: src/lzfd_checker.sv
// Port-level checks for lzf_stream_decompressor, bound to the top level.
// Depends on lzfd_pkg.
`default_nettype none
module lzfd_port_checks (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ov,
	input wire logic ordy,
	input wire logic [3:0] bc,
	input wire logic rl,
	input wire logic [1:0] es
);
	import lzfd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !ordy |=> ov) else $error("beat dropped under stall");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ov |-> bc <= 4'(OUT_LANES)) else $error("byte_count too large");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !rl |-> es == ST_RUN) else $error("status on inner word");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !rl |-> bc == 4'(OUT_LANES)) else $error("partial inner word");
endmodule

bind lzf_stream_decompressor lzfd_port_checks u_chk (
	.clk(clk), .arst_n(arst_n), .ov(out_ch.valid), .ordy(out_ch.ready),
	.bc(out_ch.data.byte_count), .rl(out_ch.data.run_last),
	.es(out_ch.data.end_status));
`default_nettype wire
